FILE: hdl/vrrp_pkg.sv
package vrrp_pkg;

    // Role codes as carried on the result channel.
    typedef enum logic [1:0] {
        ROLE_INIT   = 2'd0,
        ROLE_BACKUP = 2'd1,
        ROLE_MASTER = 2'd2
    } role_t;

    // Input item codes; code 3 carries no meaning and is ignored.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ADVERT = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OWN_PRIORITY   = 3'd0;
    localparam logic [2:0] CFG_ADV_INTERVAL   = 3'd1;
    localparam logic [2:0] CFG_PREEMPT_ENABLE = 3'd2;
    localparam logic [2:0] CFG_OWN_ADDR_HIGH  = 3'd3;
    localparam logic [2:0] CFG_OWN_ADDR_LOW   = 3'd4;

    localparam int          COUNT_W        = 18;
    localparam logic [7:0]  OWNER_PRIORITY = 8'd255;
    localparam logic [8:0]  TICKS_PER_SEC  = 9'd256;
    localparam logic [1:0]  DOWN_FACTOR    = 2'd3;

    // Register reset values.
    localparam logic [7:0]  RST_OWN_PRIORITY = 8'd100;
    localparam logic [7:0]  RST_ADV_INTERVAL = 8'd1;
    localparam logic        RST_PREEMPT      = 1'b1;

endpackage

FILE: hdl/vrrp_router_state_machine.sv
// Role machine of one virtual router: init, backup and master.
//
// Input channel (s_valid/s_ready): one item per transfer, either a start
// command, an advertisement that has already been validated, or a time tick
// of 1/256 second. Result channel (m_valid/m_ready): exactly one result per
// item, in order, giving the role after the item and the send, claim and
// release actions it calls for.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata) and
// is to be written only while no item is in flight.
//
// An accepted item is held in an input register; when the output register is
// free, the role and timer are updated and the result is loaded into the
// output register. Throughput is one item per cycle while the receiver does
// not stall, set by the compare and timer logic between the two registers.
// When the receiver stalls the output register holds its result, and the
// input register takes one more item before s_ready falls.
// Synchronous reset puts the machine in the init role with the timer
// disarmed and the configuration registers at their default values.
module vrrp_router_state_machine
    import vrrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_adv_priority,
    input  logic [63:0] s_src_addr_high,
    input  logic [63:0] s_src_addr_low,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_role,
    output logic        m_send_advert,
    output logic        m_claim_address,
    output logic        m_release_address
);

    // Configuration registers.
    logic [7:0]  own_priority_reg;
    logic [7:0]  adv_interval_reg;
    logic        preempt_enable_reg;
    logic [63:0] own_addr_high_reg;
    logic [63:0] own_addr_low_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  opcode_reg;
    logic [7:0]  adv_priority_reg;
    logic [63:0] src_addr_high_reg;
    logic [63:0] src_addr_low_reg;

    // Machine state.
    role_t              role_reg,  role_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  out_role_reg;
    logic        send_reg,    send_next;
    logic        claim_reg,   claim_next;
    logic        release_reg, release_next;

    logic               out_free;
    logic               advance;
    logic [8:0]         skew_ticks;
    logic [COUNT_W-1:0] advert_ticks;
    logic [COUNT_W-1:0] down_ticks;
    logic               peer_wins;
    logic [COUNT_W-1:0] count_dec;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Timer loads in ticks, from the register values at the moment of loading.
    assign skew_ticks   = TICKS_PER_SEC - {1'b0, own_priority_reg};
    assign advert_ticks = {2'b00, adv_interval_reg, 8'h00};
    assign down_ticks   = COUNT_W'({10'(DOWN_FACTOR) * 10'(adv_interval_reg), 8'h00})
                        + {{(COUNT_W-9){1'b0}}, skew_ticks};

    // Priority wins outright; an equal priority falls back to the address.
    assign peer_wins = (adv_priority_reg > own_priority_reg)
                    || ((adv_priority_reg == own_priority_reg)
                        && ({src_addr_high_reg, src_addr_low_reg}
                            > {own_addr_high_reg, own_addr_low_reg}));

    assign count_dec = count_reg - COUNT_W'(1);

    always_comb begin
        role_next    = role_reg;
        count_next   = count_reg;
        send_next    = 1'b0;
        claim_next   = 1'b0;
        release_next = 1'b0;
        case (opcode_reg)
            OP_START: begin
                if (own_priority_reg == OWNER_PRIORITY) begin
                    role_next  = ROLE_MASTER;
                    count_next = advert_ticks;
                    send_next  = 1'b1;
                    claim_next = 1'b1;
                end else begin
                    role_next    = ROLE_BACKUP;
                    count_next   = down_ticks;
                    release_next = 1'b1;
                end
            end
            OP_ADVERT: begin
                if (role_reg == ROLE_MASTER) begin
                    if (adv_priority_reg == 8'd0) begin
                        send_next  = 1'b1;
                        count_next = advert_ticks;
                    end else if (peer_wins) begin
                        role_next    = ROLE_BACKUP;
                        count_next   = down_ticks;
                        release_next = 1'b1;
                    end
                end else if (role_reg == ROLE_BACKUP) begin
                    if (adv_priority_reg == 8'd0) begin
                        count_next = {{(COUNT_W-9){1'b0}}, skew_ticks};
                    end else if (!preempt_enable_reg
                                 || (adv_priority_reg >= own_priority_reg)) begin
                        count_next = down_ticks;
                    end
                end
            end
            OP_TICK: begin
                if (count_reg != '0) begin
                    count_next = count_dec;
                    if (count_dec == '0) begin
                        if (role_reg == ROLE_MASTER) begin
                            send_next  = 1'b1;
                            count_next = advert_ticks;
                        end else if (role_reg == ROLE_BACKUP) begin
                            role_next  = ROLE_MASTER;
                            count_next = advert_ticks;
                            send_next  = 1'b1;
                            claim_next = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_priority_reg   <= RST_OWN_PRIORITY;
            adv_interval_reg   <= RST_ADV_INTERVAL;
            preempt_enable_reg <= RST_PREEMPT;
            own_addr_high_reg  <= '0;
            own_addr_low_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_PRIORITY:   own_priority_reg   <= cfg_wdata[7:0];
                CFG_ADV_INTERVAL:   adv_interval_reg   <= cfg_wdata[7:0];
                CFG_PREEMPT_ENABLE: preempt_enable_reg <= cfg_wdata[0];
                CFG_OWN_ADDR_HIGH:  own_addr_high_reg  <= cfg_wdata;
                CFG_OWN_ADDR_LOW:   own_addr_low_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            role_reg      <= ROLE_INIT;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                role_reg  <= role_next;
                count_reg <= count_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            opcode_reg        <= s_opcode;
            adv_priority_reg  <= s_adv_priority;
            src_addr_high_reg <= s_src_addr_high;
            src_addr_low_reg  <= s_src_addr_low;
        end
        if (advance) begin
            out_role_reg <= role_next;
            send_reg     <= send_next;
            claim_reg    <= claim_next;
            release_reg  <= release_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_role            = out_role_reg;
    assign m_send_advert     = send_reg;
    assign m_claim_address   = claim_reg;
    assign m_release_address = release_reg;

    // Claiming the address only happens on entry to master, with an advert.
    a_claim_master: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && claim_reg |-> (out_role_reg == ROLE_MASTER) && send_reg)
        else $error("claim without master role and advert");

    // Releasing the address only happens on entry to backup.
    a_release_backup: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && release_reg
            |-> (out_role_reg == ROLE_BACKUP) && !claim_reg && !send_reg)
        else $error("release without backup role");

    // The init role never has a running timer.
    a_init_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        (role_reg == ROLE_INIT) |-> (count_reg == '0))
        else $error("timer armed in init role");

    // A stalled result keeps the machine state frozen behind it.
    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready
            |=> $stable(role_reg) && $stable(count_reg))
        else $error("state moved while the result was stalled");

endmodule
